>>> design/fsqrt_pkg.sv
// ----------------------------------------------------------------------------
// fsqrt_pkg: shared types, constants and coefficient tables
// Coefficient ROMs for the degree-2 square root approximation.
// ----------------------------------------------------------------------------
package fsqrt_pkg;

	// register stages in the datapath; fixed by the stage split in the top level
	localparam int unsigned Stages = 4;
	localparam logic [31:0] QnanBits = 32'h7FC0_0000;
	localparam logic [31:0] NegQnanBits = 32'hFFC0_0000;
	localparam logic [22:0] FracMask = 23'h7F_FFFF;
	localparam logic [8:0] ExpBiasHalf = 9'h07E;

	// classification of one word after the front stage
	typedef enum logic [1:0] {
		KIND_NORMAL,
		KIND_BYPASS
	} kind_t;

	localparam logic [25:0] C0_TABLE [256] = '{
		26'd4, 26'd261638, 26'd522260, 26'd781881, 26'd1040514, 26'd1298168,
		26'd1554856, 26'd1810587, 26'd2065374, 26'd2319225, 26'd2572151,
		26'd2824163, 26'd3075270, 26'd3325482, 26'd3574807, 26'd3823257,
		26'd4070839, 26'd4317563, 26'd4563438, 26'd4808472, 26'd5052675,
		26'd5296053, 26'd5538616, 26'd5780372, 26'd6021329, 26'd6261495,
		26'd6500876, 26'd6739482, 26'd6977320, 26'd7214396, 26'd7450719,
		26'd7686295, 26'd7921131, 26'd8155234, 26'd8388612, 26'd8621270,
		26'd8853216, 26'd9084456, 26'd9314996, 26'd9544843, 26'd9774002,
		26'd10002481, 26'd10230284, 26'd10457419, 26'd10683890, 26'd10909704,
		26'd11134867, 26'd11359383, 26'd11583258, 26'd11806499, 26'd12029110,
		26'd12251096, 26'd12472463, 26'd12693216, 26'd12913360, 26'd13132900,
		26'd13351841, 26'd13570188, 26'd13787946, 26'd14005119, 26'd14221712,
		26'd14437730, 26'd14653177, 26'd14868058, 26'd15082377, 26'd15296139,
		26'd15509347, 26'd15722007, 26'd15934122, 26'd16145697, 26'd16356736,
		26'd16567242, 26'd16777220, 26'd16986674, 26'd17195607, 26'd17404024,
		26'd17611928, 26'd17819323, 26'd18026213, 26'd18232601, 26'd18438492,
		26'd18643888, 26'd18848793, 26'd19053211, 26'd19257145, 26'd19460599,
		26'd19663576, 26'd19866079, 26'd20068112, 26'd20269677, 26'd20470779,
		26'd20671420, 26'd20871603, 26'd21071332, 26'd21270609, 26'd21469439,
		26'd21667822, 26'd21865764, 26'd22063266, 26'd22260332, 26'd22456964,
		26'd22653165, 26'd22848939, 26'd23044287, 26'd23239213, 26'd23433719,
		26'd23627809, 26'd23821484, 26'd24014747, 26'd24207602, 26'd24400050,
		26'd24592094, 26'd24783737, 26'd24974980, 26'd25165828, 26'd25356282,
		26'd25546344, 26'd25736017, 26'd25925303, 26'd26114205, 26'd26302725,
		26'd26490866, 26'd26678629, 26'd26866016, 26'd27053031, 26'd27239675,
		26'd27425951, 26'd27611860, 26'd27797405, 26'd28167411, 26'd28535987,
		26'd28903148, 26'd29268908, 26'd29633286, 26'd29996298, 26'd30357956,
		26'd30718279, 26'd31077279, 26'd31434971, 26'd31791369, 26'd32146489,
		26'd32500341, 26'd32852941, 26'd33204301, 26'd33554436, 26'd33903356,
		26'd34251075, 26'd34597608, 26'd34942961, 26'd35287150, 26'd35630186,
		26'd35972081, 26'd36312846, 26'd36652491, 26'd36991027, 26'd37328468,
		26'd37664821, 26'd38000096, 26'd38334307, 26'd38667462, 26'd38999571,
		26'd39330644, 26'd39660689, 26'd39989718, 26'd40317738, 26'd40644761,
		26'd40970794, 26'd41295846, 26'd41619927, 26'd41943043, 26'd42265207,
		26'd42586423, 26'd42906703, 26'd43226051, 26'd43544480, 26'd43861993,
		26'd44178602, 26'd44494310, 26'd44809130, 26'd45123066, 26'd45436126,
		26'd45748318, 26'd46059649, 26'd46370126, 26'd46679756, 26'd46988544,
		26'd47296501, 26'd47603630, 26'd47909938, 26'd48215434, 26'd48520121,
		26'd48824010, 26'd49127102, 26'd49429406, 26'd49730929, 26'd50031676,
		26'd50331652, 26'd50630865, 26'd50929318, 26'd51227019, 26'd51523972,
		26'd51820184, 26'd52115662, 26'd52410407, 26'd52704428, 26'd52997728,
		26'd53290315, 26'd53582193, 26'd53873366, 26'd54163839, 26'd54453618,
		26'd54742709, 26'd55031116, 26'd55318843, 26'd55605895, 26'd55892279,
		26'd56177996, 26'd56463053, 26'd56747453, 26'd57031203, 26'd57314304,
		26'd57596764, 26'd57878584, 26'd58159772, 26'd58440328, 26'd58720259,
		26'd58999571, 26'd59278263, 26'd59556342, 26'd59833814, 26'd60110679,
		26'd60386943, 26'd60662611, 26'd60937684, 26'd61212169, 26'd61486065,
		26'd61759382, 26'd62032118, 26'd62304281, 26'd62575872, 26'd62846896,
		26'd63117356, 26'd63387254, 26'd63656598, 26'd63925385, 26'd64193624,
		26'd64461315, 26'd64728463, 26'd64995070, 26'd65261142, 26'd65526678,
		26'd65791684, 26'd66056163, 26'd66320119, 26'd66583552, 26'd66846468
	};

	localparam logic [16:0] C1_TABLE [256] = '{
		17'd131071, 17'd130562, 17'd130059, 17'd129563, 17'd129070, 17'd128584,
		17'd128103, 17'd127629, 17'd127157, 17'd126693, 17'd126234, 17'd125779,
		17'd125329, 17'd124883, 17'd124443, 17'd124007, 17'd123576, 17'd123149,
		17'd122727, 17'd122309, 17'd121893, 17'd121485, 17'd121080, 17'd120678,
		17'd120279, 17'd119885, 17'd119497, 17'd119111, 17'd118727, 17'd118349,
		17'd117973, 17'd117601, 17'd117234, 17'd116870, 17'd116509, 17'd116151,
		17'd115796, 17'd115444, 17'd115096, 17'd114750, 17'd114409, 17'd114070,
		17'd113734, 17'd113401, 17'd113071, 17'd112744, 17'd112418, 17'd112097,
		17'd111779, 17'd111462, 17'd111148, 17'd110838, 17'd110530, 17'd110224,
		17'd109921, 17'd109620, 17'd109322, 17'd109026, 17'd108732, 17'd108441,
		17'd108152, 17'd107866, 17'd107581, 17'd107299, 17'd107019, 17'd106742,
		17'd106467, 17'd106194, 17'd105923, 17'd105653, 17'd105385, 17'd105121,
		17'd104857, 17'd104596, 17'd104337, 17'd104079, 17'd103824, 17'd103571,
		17'd103319, 17'd103070, 17'd102821, 17'd102575, 17'd102331, 17'd102088,
		17'd101847, 17'd101607, 17'd101369, 17'd101133, 17'd100898, 17'd100666,
		17'd100434, 17'd100205, 17'd99977, 17'd99751, 17'd99527, 17'd99302,
		17'd99082, 17'd98861, 17'd98642, 17'd98424, 17'd98208, 17'd97994,
		17'd97780, 17'd97569, 17'd97358, 17'd97149, 17'd96940, 17'd96734,
		17'd96530, 17'd96325, 17'd96122, 17'd95921, 17'd95720, 17'd95523,
		17'd95325, 17'd95128, 17'd94933, 17'd94740, 17'd94548, 17'd94356,
		17'd94165, 17'd93975, 17'd93787, 17'd93601, 17'd93415, 17'd93231,
		17'd93047, 17'd92864, 17'd92682, 17'd92322, 17'd91966, 17'd91613,
		17'd91266, 17'd90924, 17'd90583, 17'd90248, 17'd89915, 17'd89586,
		17'd89260, 17'd88939, 17'd88620, 17'd88306, 17'd87995, 17'd87686,
		17'd87381, 17'd87080, 17'd86781, 17'd86484, 17'd86192, 17'd85903,
		17'd85615, 17'd85332, 17'd85050, 17'd84772, 17'd84497, 17'd84223,
		17'd83952, 17'd83686, 17'd83420, 17'd83158, 17'd82897, 17'd82639,
		17'd82384, 17'd82130, 17'd81880, 17'd81631, 17'd81385, 17'd81141,
		17'd80899, 17'd80660, 17'd80422, 17'd80187, 17'd79953, 17'd79722,
		17'd79492, 17'd79265, 17'd79039, 17'd78816, 17'd78594, 17'd78374,
		17'd78157, 17'd77940, 17'd77726, 17'd77513, 17'd77301, 17'd77093,
		17'd76884, 17'd76679, 17'd76475, 17'd76272, 17'd76072, 17'd75871,
		17'd75675, 17'd75478, 17'd75283, 17'd75090, 17'd74898, 17'd74707,
		17'd74519, 17'd74331, 17'd74146, 17'd73961, 17'd73776, 17'd73595,
		17'd73414, 17'd73235, 17'd73058, 17'd72880, 17'd72705, 17'd72531,
		17'd72359, 17'd72187, 17'd72016, 17'd71848, 17'd71679, 17'd71512,
		17'd71346, 17'd71181, 17'd71019, 17'd70856, 17'd70694, 17'd70534,
		17'd70376, 17'd70217, 17'd70061, 17'd69906, 17'd69750, 17'd69597,
		17'd69444, 17'd69292, 17'd69141, 17'd68991, 17'd68842, 17'd68694,
		17'd68546, 17'd68402, 17'd68256, 17'd68113, 17'd67969, 17'd67827,
		17'd67686, 17'd67544, 17'd67406, 17'd67265, 17'd67129, 17'd66991,
		17'd66855, 17'd66719, 17'd66585, 17'd66450, 17'd66318, 17'd66186,
		17'd66054, 17'd65923, 17'd65793, 17'd65664
	};

	localparam logic [8:0] C2_TABLE [256] = '{
		9'd508, 9'd502, 9'd497, 9'd494, 9'd486, 9'd480, 9'd475, 9'd471, 9'd463,
		9'd460, 9'd456, 9'd451, 9'd447, 9'd441, 9'd436, 9'd432, 9'd428, 9'd423,
		9'd420, 9'd416, 9'd408, 9'd407, 9'd404, 9'd399, 9'd392, 9'd389, 9'd388,
		9'd384, 9'd378, 9'd375, 9'd370, 9'd366, 9'd365, 9'd362, 9'd360, 9'd356,
		9'd352, 9'd348, 9'd345, 9'd341, 9'd339, 9'd337, 9'd333, 9'd331, 9'd328,
		9'd326, 9'd320, 9'd319, 9'd317, 9'd313, 9'd310, 9'd309, 9'd307, 9'd304,
		9'd302, 9'd299, 9'd297, 9'd294, 9'd291, 9'd289, 9'd286, 9'd285, 9'd281,
		9'd279, 9'd276, 9'd276, 9'd274, 9'd273, 9'd271, 9'd267, 9'd264, 9'd264,
		9'd260, 9'd259, 9'd257, 9'd254, 9'd253, 9'd252, 9'd250, 9'd249, 9'd246,
		9'd245, 9'd244, 9'd242, 9'd240, 9'd237, 9'd235, 9'd233, 9'd231, 9'd230,
		9'd227, 9'd227, 9'd225, 9'd225, 9'd225, 9'd220, 9'd222, 9'd220, 9'd218,
		9'd216, 9'd215, 9'd214, 9'd212, 9'd212, 9'd210, 9'd208, 9'd205, 9'd205,
		9'd205, 9'd202, 9'd200, 9'd199, 9'd196, 9'd198, 9'd196, 9'd194, 9'd193,
		9'd194, 9'd194, 9'd192, 9'd189, 9'd187, 9'd187, 9'd187, 9'd186, 9'd186,
		9'd185, 9'd182, 9'd180, 9'd178, 9'd176, 9'd173, 9'd171, 9'd171, 9'd168,
		9'd167, 9'd165, 9'd163, 9'd160, 9'd159, 9'd157, 9'd156, 9'd155, 9'd152,
		9'd151, 9'd150, 9'd148, 9'd146, 9'd145, 9'd144, 9'd141, 9'd141, 9'd139,
		9'd138, 9'd137, 9'd135, 9'd133, 9'd133, 9'd131, 9'd131, 9'd129, 9'd128,
		9'd127, 9'd125, 9'd124, 9'd123, 9'd122, 9'd121, 9'd120, 9'd119, 9'd118,
		9'd117, 9'd116, 9'd115, 9'd114, 9'd113, 9'd112, 9'd111, 9'd110, 9'd109,
		9'd109, 9'd107, 9'd107, 9'd106, 9'd104, 9'd104, 9'd102, 9'd102, 9'd101,
		9'd100, 9'd100, 9'd98, 9'd99, 9'd97, 9'd96, 9'd96, 9'd95, 9'd94, 9'd94,
		9'd93, 9'd93, 9'd92, 9'd90, 9'd90, 9'd89, 9'd88, 9'd89, 9'd87, 9'd87,
		9'd86, 9'd86, 9'd85, 9'd84, 9'd85, 9'd83, 9'd83, 9'd82, 9'd81, 9'd82,
		9'd81, 9'd79, 9'd79, 9'd79, 9'd78, 9'd78, 9'd78, 9'd77, 9'd77, 9'd76,
		9'd76, 9'd75, 9'd74, 9'd74, 9'd73, 9'd72, 9'd73, 9'd72, 9'd72, 9'd71,
		9'd71, 9'd71, 9'd69, 9'd70, 9'd68, 9'd69, 9'd68, 9'd68, 9'd67, 9'd67,
		9'd66, 9'd66, 9'd66, 9'd65, 9'd65, 9'd64, 9'd64
	};

	// front stage result handed to the polynomial stages
	typedef struct packed {
		kind_t       kind;
		logic [31:0] bypass;
		logic [7:0]  zexp;
		logic [7:0]  row;
		logic [16:0] low;
	} front_t;

endpackage

>>> design/fsqrt_if.sv
// ----------------------------------------------------------------------------
// fsqrt_if: valid/ready channel carrying one binary32 word
// Source drives valid and data, sink drives ready.
// ----------------------------------------------------------------------------
interface fsqrt_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/fsqrt_front.sv
// ----------------------------------------------------------------------------
// fsqrt_front: classification, subnormal normalization, table index
// Combinational; the pipeline register follows in the top level.
// ----------------------------------------------------------------------------
module fsqrt_front (
	input  logic                  flush,
	input  logic [31:0]           x,
	output fsqrt_pkg::front_t     f
);
	logic        sign;
	logic [7:0]  ex;
	logic [22:0] fr;
	logic        is_zero;
	logic [4:0]  lz;
	logic [22:0] frn;
	logic [8:0]  exn;
	logic        odd;
	logic [8:0]  zsum;

	always_comb begin
		sign = x[31];
		ex = x[30:23];
		fr = x[22:0];
		is_zero = flush ? (ex == 8'd0) : (x[30:0] == 31'd0);
		// leading zeros of the 23-bit fraction, capped at 22
		lz = 5'd22;
		for (int i = 0; i <= 22; i++) begin
			if (fr[i]) lz = 5'(22 - i);
		end
		frn = fr;
		exn = {1'b0, ex};
		if (ex == 8'd0) begin
			frn = {(fr[21:0] << lz), 1'b0};
			exn = 9'(10'd512 - {5'd0, lz});
		end
		odd = ~exn[0];
		zsum = exn + fsqrt_pkg::ExpBiasHalf + {8'd0, exn[0]};
		f.zexp = zsum[8:1];
		f.row = {odd, frn[22:16]};
		f.low = odd ? {frn[15:0], 1'b0} : {1'b0, frn[15:0]};
		f.kind = fsqrt_pkg::KIND_BYPASS;
		if (is_zero) f.bypass = {sign, 31'd0};
		else if (ex == 8'hFF) f.bypass = ((fr != 23'd0) || sign) ?
			(x | fsqrt_pkg::QnanBits) : x;
		else if (sign) f.bypass = fsqrt_pkg::NegQnanBits;
		else begin
			f.bypass = '0;
			f.kind = fsqrt_pkg::KIND_NORMAL;
		end
	end
endmodule

>>> design/fsqrt_stall_pipe.sv
// ----------------------------------------------------------------------------
// fsqrt_stall_pipe: per-stage valid bits and enables for a stalling pipeline
// A stage advances when it is empty or the stage after it advances.
// ----------------------------------------------------------------------------
module fsqrt_stall_pipe #(
	parameter int unsigned Stages = fsqrt_pkg::Stages
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_ready,
	output logic              in_ready,
	output logic [Stages-1:0] en,
	output logic [Stages-1:0] valid_q
);
	logic [Stages:0] adv;

	always_comb begin
		adv[Stages] = out_ready;
		for (int i = Stages - 1; i >= 0; i--) begin
			adv[i] = ~valid_q[i] | adv[i+1];
		end
		en = adv[Stages-1:0];
		in_ready = adv[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) valid_q[0] <= in_valid;
			for (int i = 1; i < Stages; i++) begin
				if (en[i]) valid_q[i] <= valid_q[i-1];
			end
		end
	end

	valid_hold_a: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[Stages-1] && !out_ready |=> valid_q[Stages-1])
		else $error("output valid dropped while stalled");
	no_take_when_full_a: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q[0] && !en[0]) |-> !in_ready)
		else $error("input taken while first stage stalled");
	advance_a: assert property (@(posedge clk) disable iff (!arst_n)
		(en[0] && in_valid) |=> valid_q[0])
		else $error("accepted word lost in first stage");
endmodule

>>> design/float32_square_root.sv
// ----------------------------------------------------------------------------
// float32_square_root: pipelined binary32 square root, one word per cycle
// ----------------------------------------------------------------------------
// Input words arrive on operand (valid/ready), results leave on root in the
// same order. A word is taken when valid and ready are both high.
// Throughput: one word per cycle while root.ready is high. Stages:
// (1) classify, normalize, index tables; (2) table read and low*c2;
// (3) c1 - p2, low*p1; (4) add c0, truncate, saturate, pack.
// flush_subnormals is written with cfg_we/cfg_wdata; the user must do so
// only while idle, which the block does not enforce. It selects whether
// exponent-zero inputs flush to signed zero. Reset empties the pipeline and
// clears flush_subnormals. While root.ready is low, the output stage holds;
// any empty stage still fills, so up to four words are held inside.
// ----------------------------------------------------------------------------
module float32_square_root (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	fsqrt_if.sink        operand,
	fsqrt_if.source      root
);
	logic                          flush_q;
	logic [fsqrt_pkg::Stages-1:0]  en;
	logic [fsqrt_pkg::Stages-1:0]  vld;
	fsqrt_pkg::front_t   f;

	fsqrt_pkg::front_t   f_s1;
	fsqrt_pkg::kind_t    kind_s2, kind_s3;
	logic [31:0]         byp_s2, byp_s3, out_s4;
	logic [7:0]          zexp_s2, zexp_s3;
	logic [16:0]         low_s2;
	logic [16:0]         c1_s2;
	logic [25:0]         c0_s2, c0_s3;
	logic [25:0]         prod2_s2;
	logic [33:0]         prod1_s3;
	logic [8:0]          p2;
	logic [16:0]         p1;
	logic [18:0]         p0;
	logic [26:0]         zsum;
	logic [22:0]         zfrac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) flush_q <= 1'b0;
		else if (cfg_we) flush_q <= cfg_wdata[0];
	end

	fsqrt_front u_front (.flush(flush_q), .x(operand.data), .f(f));

	fsqrt_stall_pipe #(.Stages(fsqrt_pkg::Stages)) u_pipe (
		.clk(clk), .arst_n(arst_n), .in_valid(operand.valid),
		.out_ready(root.ready), .in_ready(operand.ready),
		.en(en), .valid_q(vld)
	);

	always_comb begin
		p2 = prod2_s2[25:17];
		p1 = c1_s2 - {8'd0, p2};
		p0 = prod1_s3[33:15];
		zsum = {1'b0, c0_s3} + {8'd0, p0};
		zfrac = zsum[26] ? fsqrt_pkg::FracMask : zsum[25:3];
	end

	always_ff @(posedge clk) begin
		if (en[0]) f_s1 <= f;
		if (en[1]) begin
			kind_s2 <= f_s1.kind;
			byp_s2 <= f_s1.bypass;
			zexp_s2 <= f_s1.zexp;
			low_s2 <= f_s1.low;
			c0_s2 <= fsqrt_pkg::C0_TABLE[f_s1.row];
			c1_s2 <= fsqrt_pkg::C1_TABLE[f_s1.row];
			prod2_s2 <= f_s1.low * fsqrt_pkg::C2_TABLE[f_s1.row];
		end
		if (en[2]) begin
			kind_s3 <= kind_s2;
			byp_s3 <= byp_s2;
			zexp_s3 <= zexp_s2;
			c0_s3 <= c0_s2;
			prod1_s3 <= low_s2 * p1;
		end
		if (en[3]) begin
			out_s4 <= (kind_s3 == fsqrt_pkg::KIND_BYPASS) ? byp_s3 :
				{1'b0, zexp_s3, zfrac};
		end
	end

	assign root.valid = vld[fsqrt_pkg::Stages-1];
	assign root.data = out_s4;
endmodule
